/* rtl/sha1h_pkg.sv */
`timescale 1ns / 1ps

package sha1h_pkg;

  typedef logic [31:0] word_t;

  // Working variables of the compression rounds.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } work_t;

  localparam int HASH_WORDS = 5;
  localparam int RING_WORDS = 16;

  localparam word_t SHA_K0 = 32'h5a827999;
  localparam word_t SHA_K1 = 32'h6ed9eba1;
  localparam word_t SHA_K2 = 32'h8f1bbcdc;
  localparam word_t SHA_K3 = 32'hca62c1d6;

  localparam word_t H_INIT [HASH_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [7:0] PAD_MARK       = 8'h80;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;
  localparam logic [5:0] FILL_LAST      = 6'd63;
  localparam logic [5:0] FILL_LEN_START = 6'd56;
  localparam logic [6:0] ROUND_LAST     = 7'd79;
  localparam logic [6:0] ROUND_END_P1   = 7'd20;
  localparam logic [6:0] ROUND_END_P2   = 7'd40;
  localparam logic [6:0] ROUND_END_P3   = 7'd60;
  localparam logic [2:0] LAST_WORD_IDX  = 3'd4;
  localparam logic [2:0] LAST_LEN_IDX   = 3'd7;

  function automatic word_t rotl1(input word_t x);
    return {x[30:0], x[31]};
  endfunction

endpackage

/* rtl/sha1h_in_if.sv */
`timescale 1ns / 1ps

interface sha1h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, output data_byte, output byte_present,
                  output last_byte, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input last_byte, output ready);
endinterface

/* rtl/sha1h_out_if.sv */
`timescale 1ns / 1ps

interface sha1h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

/* rtl/sha1_byte_stream_hasher.sv */
`timescale 1ns / 1ps

// SHA-1 hasher for a byte stream. Each input beat carries at most one message
// byte and may mark the end of the message; an end beat without a byte is
// allowed, so the empty message hashes correctly. A byte that completes a
// 64-byte block starts a compression: a single round unit iterates over the
// rounds, and the final hash update follows. An end beat then appends the
// padding one byte per cycle except while a compression runs (the 0x80
// marker, zeros up to byte 56, a pause without a byte to switch phase, and
// the eight length bytes), with one or two further compressions, and finally
// presents the digest as five 32-bit output beats, most significant word
// first. The input is not ready while rounds, padding or digest beats are in
// progress. After the fifth word is taken the hash state, byte count and bit
// count return to their initial values and the next message may start at
// once.
module sha1_byte_stream_hasher import sha1h_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sha1h_in_if.sink    in_if,
  sha1h_out_if.source out_if
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP,
    S_FIN,
    S_PAD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } phase_t;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  word_t       hash_r [HASH_WORDS];
  word_t       hash_nxt [HASH_WORDS];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bit_len_r, bit_len_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [2:0]  len_idx_r, len_idx_nxt;
  logic        len_done_r, len_done_nxt;
  logic        pad_pend_r, pad_pend_nxt;
  logic [2:0]  word_idx_r, word_idx_nxt;
  work_t       work_r, work_nxt;
  word_t       w_r [RING_WORDS];

  logic        absorb_en;
  logic [7:0]  absorb_val;
  logic [3:0]  slot;
  logic [63:0] len_shifted;
  work_t       round_out;
  work_t       hash_work;
  logic        in_beat;
  logic        out_beat;

  assign in_beat  = in_if.valid && in_if.ready;
  assign out_beat = out_if.valid && out_if.ready;
  assign slot     = fill_r[5:2];

  // Length bytes go out most significant first.
  assign len_shifted = bit_len_r >> {~len_idx_r, 3'b000};

  assign hash_work = '{a: hash_r[0], b: hash_r[1], c: hash_r[2],
                       d: hash_r[3], e: hash_r[4]};

  sha1h_round u_round (
    .cur   (work_r),
    .w     (w_r[0]),
    .round (round_r),
    .nxt   (round_out)
  );

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    hash_nxt     = hash_r;
    fill_nxt     = fill_r;
    bit_len_nxt  = bit_len_r;
    round_nxt    = round_r;
    len_idx_nxt  = len_idx_r;
    len_done_nxt = len_done_r;
    pad_pend_nxt = pad_pend_r;
    word_idx_nxt = word_idx_r;
    work_nxt     = work_r;
    absorb_en    = 1'b0;
    absorb_val   = ZERO_BYTE;

    unique case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          pad_pend_nxt = in_if.last_byte;
          phase_nxt    = PH_MARK;
          if (in_if.last_byte) begin
            state_nxt = S_PAD;
          end
          if (in_if.byte_present) begin
            absorb_en   = 1'b1;
            absorb_val  = in_if.data_byte;
            bit_len_nxt = bit_len_r + 64'd8;
          end
        end
      end
      S_COMP: begin
        work_nxt  = round_out;
        round_nxt = round_r + 7'd1;
        if (round_r == ROUND_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        hash_nxt[0] = hash_r[0] + work_r.a;
        hash_nxt[1] = hash_r[1] + work_r.b;
        hash_nxt[2] = hash_r[2] + work_r.c;
        hash_nxt[3] = hash_r[3] + work_r.d;
        hash_nxt[4] = hash_r[4] + work_r.e;
        priority if (!pad_pend_r) begin
          state_nxt = S_IDLE;
        end else if (len_done_r) begin
          state_nxt    = S_OUT;
          word_idx_nxt = '0;
        end else begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        unique case (phase_r)
          PH_MARK: begin
            absorb_en  = 1'b1;
            absorb_val = PAD_MARK;
            phase_nxt  = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill_r == FILL_LEN_START) begin
              phase_nxt   = PH_LEN;
              len_idx_nxt = '0;
            end else begin
              absorb_en = 1'b1;
            end
          end
          PH_LEN: begin
            absorb_en   = 1'b1;
            absorb_val  = len_shifted[7:0];
            len_idx_nxt = len_idx_r + 3'd1;
            if (len_idx_r == LAST_LEN_IDX) begin
              len_done_nxt = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_MARK;
          end
        endcase
      end
      S_OUT: begin
        if (out_beat) begin
          word_idx_nxt = word_idx_r + 3'd1;
          if (word_idx_r == LAST_WORD_IDX) begin
            state_nxt    = S_IDLE;
            hash_nxt     = H_INIT;
            bit_len_nxt  = '0;
            pad_pend_nxt = 1'b0;
            len_done_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A byte that fills the block starts the rounds from the current hash.
    if (absorb_en) begin
      fill_nxt = fill_r + 6'd1;
      if (fill_r == FILL_LAST) begin
        state_nxt = S_COMP;
        round_nxt = '0;
        work_nxt  = hash_work;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      phase_r    <= PH_MARK;
      hash_r     <= H_INIT;
      fill_r     <= '0;
      bit_len_r  <= '0;
      round_r    <= '0;
      len_idx_r  <= '0;
      len_done_r <= 1'b0;
      pad_pend_r <= 1'b0;
      word_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      hash_r     <= hash_nxt;
      fill_r     <= fill_nxt;
      bit_len_r  <= bit_len_nxt;
      round_r    <= round_nxt;
      len_idx_r  <= len_idx_nxt;
      len_done_r <= len_done_nxt;
      pad_pend_r <= pad_pend_nxt;
      word_idx_r <= word_idx_nxt;
    end
    work_r <= work_nxt;
  end

  // Message schedule window. During the rounds it slides by one word a cycle
  // so that the word for the current round always sits at the bottom; the
  // message words it overwrites are rebuilt by the byte loads of the next block.
  always_ff @(posedge clk) begin
    if (state_r == S_COMP) begin
      for (int j = 0; j < RING_WORDS - 1; j++) begin
        w_r[j] <= w_r[j + 1];
      end
      w_r[RING_WORDS - 1] <= rotl1(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]);
    end else if (absorb_en) begin
      w_r[slot] <= {w_r[slot][23:0], absorb_val};
    end
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = (state_r == S_OUT);
  assign out_if.digest_word = hash_r[word_idx_r];
  assign out_if.word_index  = word_idx_r;
  assign out_if.last_word   = (word_idx_r == LAST_WORD_IDX);

endmodule

/* rtl/sha1h_round.sv */
`timescale 1ns / 1ps

// One SHA-1 round: selects the round function and constant by round number.
module sha1h_round import sha1h_pkg::*; (
  input  work_t      cur,
  input  word_t      w,
  input  logic [6:0] round,
  output work_t      nxt
);

  word_t f;
  word_t k;
  word_t t;

  always_comb begin
    priority if (round < ROUND_END_P1) begin
      f = ((cur.c ^ cur.d) & cur.b) ^ cur.d;
      k = SHA_K0;
    end else if (round < ROUND_END_P2) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = SHA_K1;
    end else if (round < ROUND_END_P3) begin
      f = (cur.b & cur.c) | (cur.d & (cur.b | cur.c));
      k = SHA_K2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = SHA_K3;
    end
  end

  assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + w + k;

  assign nxt.a = t;
  assign nxt.b = cur.a;
  assign nxt.c = {cur.b[1:0], cur.b[31:2]};
  assign nxt.d = cur.c;
  assign nxt.e = cur.d;

endmodule

/* rtl/sha1h_checker.sv */
`timescale 1ns / 1ps

module sha1h_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // Input and digest beats never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest beats are pending");

  // An end beat always leads into padding.
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_byte) |=> !in_ready)
    else $error("input ready right after an end beat");

  // Digest words come in order without gaps.
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest word sequence broken");

  // The last word is index four.
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd4)))
    else $error("last_word does not match word_index");

  // After the final word the block takes a new message.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (in_ready && !out_valid))
    else $error("block not idle after the final digest word");

endmodule

bind sha1_byte_stream_hasher sha1h_checker u_sha1h_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .in_last_byte   (in_if.last_byte),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_word_index (out_if.word_index),
  .out_last_word  (out_if.last_word)
);

/* verif/sha1_byte_stream_hasher_test.sv */
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_test;
  import sha1h_pkg::*;

  // Run control. The cycle limit is far above the slowest legal run, in which
  // each block costs a compression, each message adds its padding, and both
  // sides stall at random with a 29 percent chance per draw.
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int IDLE_PCT     = 29;
  localparam int RANDOM_BEATS = 140;
  localparam int DRAIN_CYCLES = 200;

  // The calm window covers these random beats; neither side idles there.
  localparam int CALM_FIRST = 40;
  localparam int CALM_LAST  = 100;

  // SHA-1 initial hash and round constants, kept apart from the package so
  // that a wrong constant in the design cannot hide in the prediction.
  localparam word_t IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam word_t ROUND_K [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };
  localparam logic [7:0] END_MARK     = 8'h80;
  localparam logic [5:0] LEN_FIELD_AT = 6'd56;
  localparam logic [2:0] TOP_WORD     = 3'd4;

  // Message lengths that put the padding on every side of a block boundary.
  localparam int EDGE_LENS [6] = '{55, 56, 57, 63, 64, 65};

  // One row of the directed part. Where known is set, the digest is the
  // published value and is used as the expectation as it stands.
  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         fin;
    logic         known;
    logic [159:0] digest;
  } row_t;

  localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  localparam int DIRECTED_ROWS = 13;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    // The empty message straight after reset: an end beat with no byte.
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    // A beat with neither byte nor end changes nothing, so the next empty
    // message must hash the same way again.
    '{8'hff, 1'b0, 1'b0, 1'b0, '0},
    '{8'ha5, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    // "abc", with the final byte and the end on the same beat.
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    // Extreme byte values, closed by an end beat whose ignored byte is set.
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'hff, 1'b1, 1'b0, 1'b0, '0},
    '{8'h5a, 1'b0, 1'b1, 1'b0, '0},
    // One-byte messages at both extremes, byte and end together.
    '{8'hff, 1'b1, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, 1'b0, '0},
    // Idle beat between messages, then a lone end beat again.
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'hc3, 1'b0, 1'b1, 1'b0, '0}
  };

  typedef struct {
    word_t      word;
    logic [2:0] idx;
    logic       fin;
  } digest_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  sha1h_in_if  in_ch ();
  sha1h_out_if out_ch ();

  sha1_byte_stream_hasher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the hasher: chaining value, the sixteen message words
  // of the block being filled, the fill level in bytes and the bit count.
  word_t       hash_st [5] = IV;
  word_t       msg_words [16] = '{default: '0};
  logic [5:0]  fill = '0;
  logic [63:0] msg_bits = '0;

  // Digest words that the hasher still owes, oldest first.
  digest_beat_t want_q [$];

  bit calm = 1'b0;
  int mismatches = 0;
  int cycles = 0;
  int beats_taken = 0;
  int msgs_closed = 0;
  int words_checked = 0;

  function automatic word_t rol(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Shifts one byte into the block and runs the compression when the block
  // becomes full.
  function automatic void absorb(input logic [7:0] b);
    word_t w [80];
    word_t a, bb, c, d, e, f, k, t;
    int i;
    msg_words[fill[5:2]] = {msg_words[fill[5:2]][23:0], b};
    fill = fill + 6'd1;
    if (fill == 6'd0) begin
      for (i = 0; i < 16; i++) w[i] = msg_words[i];
      for (i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = hash_st[0];
      bb = hash_st[1];
      c = hash_st[2];
      d = hash_st[3];
      e = hash_st[4];
      for (i = 0; i < 80; i++) begin
        if (i < 20) f = ((c ^ d) & bb) ^ d;
        else if (i < 40) f = bb ^ c ^ d;
        else if (i < 60) f = (bb & c) | (d & (bb | c));
        else f = bb ^ c ^ d;
        k = ROUND_K[i / 20];
        t = rol(a, 5) + f + e + w[i] + k;
        e = d;
        d = c;
        c = rol(bb, 30);
        bb = a;
        a = t;
      end
      hash_st[0] += a;
      hash_st[1] += bb;
      hash_st[2] += c;
      hash_st[3] += d;
      hash_st[4] += e;
    end
  endfunction

  // Applies one accepted input beat and returns how many digest words it
  // causes (zero or five); the words land in dig.
  function automatic int hash_beat(input logic [7:0] data, input logic present,
                                   input logic fin, output word_t dig [5]);
    logic [63:0] len;
    int i;
    for (i = 0; i < 5; i++) dig[i] = '0;
    if (present) begin
      absorb(data);
      msg_bits = msg_bits + 64'd8;
    end
    if (!fin) return 0;
    // Padding: the end marker, zeros up to the length field, then the bit
    // count most significant byte first.
    len = msg_bits;
    absorb(END_MARK);
    while (fill != LEN_FIELD_AT) absorb(8'h00);
    for (i = 7; i >= 0; i--) absorb(len[8*i +: 8]);
    for (i = 0; i < 5; i++) dig[i] = hash_st[i];
    // The next message starts from the initial chaining value. The message
    // words stay as they are; each is rebuilt before it is read again.
    hash_st = IV;
    fill = '0;
    msg_bits = '0;
    return 5;
  endfunction

  // Drives one input beat and holds it until the hasher takes it. Called and
  // left at a falling edge; a random number of idle cycles may come first.
  // When known is set, the typed digest replaces the predicted one.
  task automatic send_beat(input logic [7:0] data, input logic present, input logic fin,
                           input logic known, input logic [159:0] typed);
    word_t dig [5];
    digest_beat_t nb;
    int n;
    int i;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= data;
    in_ch.byte_present <= present;
    in_ch.last_byte    <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // The beat moved at this edge; the digest comes only after the rounds and
    // the padding, so the expectations are queued well ahead of it.
    n = hash_beat(data, present, fin, dig);
    for (i = 0; i < n; i++) begin
      nb.word = known ? typed[159 - 32*i -: 32] : dig[i];
      nb.idx  = 3'(i);
      nb.fin  = (3'(i) == TOP_WORD);
      want_q.push_back(nb);
    end
    beats_taken++;
    if (fin) msgs_closed++;
    @(negedge clk);
  endtask

  // The result side stalls at random, except inside the calm window.
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Every digest beat is checked, field by field, against the oldest
  // expectation.
  always @(posedge clk) begin
    digest_beat_t exp_b;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (want_q.size() == 0) begin
        $error("unexpected digest beat: digest_word %08h word_index %0d last_word %0b",
               out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        mismatches++;
      end else begin
        exp_b = want_q.pop_front();
        words_checked++;
        if (out_ch.digest_word !== exp_b.word) begin
          $error("digest_word: expected %08h, actual %08h", exp_b.word, out_ch.digest_word);
          mismatches++;
        end
        if (out_ch.word_index !== exp_b.idx) begin
          $error("word_index: expected %0d, actual %0d", exp_b.idx, out_ch.word_index);
          mismatches++;
        end
        if (out_ch.last_word !== exp_b.fin) begin
          $error("last_word: expected %0b, actual %0b", exp_b.fin, out_ch.last_word);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sha1_byte_stream_hasher_test NOT OK");
      $finish;
    end
  end

  initial begin
    int r;
    int beats_rand;
    int len;
    int pick;
    int j;
    bit fold;
    logic [7:0] rb;

    // Every input of the hasher is known from time zero.
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_present = 1'b0;
    in_ch.last_byte    = 1'b0;
    out_ch.ready       = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: published digests where they are known, the predictor
    // elsewhere.
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      send_beat(DIRECTED[r].data, DIRECTED[r].present, DIRECTED[r].fin,
                DIRECTED[r].known, DIRECTED[r].digest);
    end

    // Random part: whole messages of random content. Most are short, a
    // quarter sit right at a block boundary so that the padding spills into
    // a second block or just fits, and a few are long. The last message is
    // cut short so that the beat count stays on its target. Idle beats with
    // neither byte nor end are sprinkled in as noise.
    beats_rand = 0;
    while (beats_rand < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) len = $urandom_range(0, 6);
      else if (pick < 85) len = EDGE_LENS[$urandom_range(0, 5)];
      else len = $urandom_range(0, 130);
      if (len > RANDOM_BEATS - beats_rand - 1) len = RANDOM_BEATS - beats_rand - 1;
      // The end either rides on the final byte or comes as a beat of its own.
      fold = (len > 0) && ($urandom_range(0, 1) == 1);
      for (j = 0; j < len; j++) begin
        calm = (beats_rand >= CALM_FIRST && beats_rand <= CALM_LAST);
        if ($urandom_range(0, 99) < 8) begin
          rb = 8'($urandom);
          send_beat(rb, 1'b0, 1'b0, 1'b0, '0);
        end
        rb = 8'($urandom);
        send_beat(rb, 1'b1, fold && (j == len - 1), 1'b0, '0);
        beats_rand++;
      end
      if (!fold) begin
        calm = (beats_rand >= CALM_FIRST && beats_rand <= CALM_LAST);
        rb = 8'($urandom);
        send_beat(rb, 1'b0, 1'b1, 1'b0, '0);
        beats_rand++;
      end
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // Drain: wait for every owed digest word, then a little longer so that a
    // stray extra beat would still be caught.
    while (want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages over %0d input beats; %0d digest words compared.",
             msgs_closed, beats_taken, words_checked);
    $display("Known digests, then random messages of mixed length near block edges.");
    if (mismatches == 0 && want_q.size() == 0) begin
      $display("sha1_byte_stream_hasher_test OK");
    end else begin
      $display("sha1_byte_stream_hasher_test NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sha1h_pkg.sv
rtl/sha1h_in_if.sv
rtl/sha1h_out_if.sv
rtl/sha1h_round.sv
rtl/sha1_byte_stream_hasher.sv
rtl/sha1h_checker.sv
verif/sha1_byte_stream_hasher_test.sv
